// File: hdl/sidelobe_window_mask_defines.svh
`ifndef SIDELOBE_WINDOW_MASK_DEFINES_SVH
`define SIDELOBE_WINDOW_MASK_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SWM_ASSERT_IMPLIES(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sidelobe window mask check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define SWM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sidelobe window mask check failed");

`endif

// File: hdl/swm_pkg.sv
package swm_pkg;

    localparam int WINDOW_SPAN_DEF  = 32;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int MAX_ROWS_DEF     = 4096;

    localparam int OFFSET_W    = 6;
    localparam int OFS_EXT_W   = 8;
    localparam int TABLE_DEPTH = 32;
    localparam int TABLE_IDX_W = 5;
    localparam int ROW_INDEX_W = 12;
    localparam int OUT_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_OFFSET   = 2'd0,
        CFG_LAST_OFFSET    = 2'd1,
        CFG_MASKING_ENABLE = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        KIND_DATA  = 1'b0,
        KIND_TABLE = 1'b1
    } item_kind_t;

    typedef struct packed {
        logic                        shift;
        logic                        col_end;
        logic                        active;
        logic signed [OFS_EXT_W-1:0] first;
        logic signed [OFS_EXT_W-1:0] hi;
        logic                        load_en;
        logic [TABLE_IDX_W-1:0]      load_idx;
    } cell_ctrl_t;

endpackage

// File: hdl/swm_cell.sv
module swm_cell #(
    parameter int AGE          = 1,
    parameter int WINDOW_SPAN  = swm_pkg::WINDOW_SPAN_DEF,
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  swm_pkg::cell_ctrl_t            ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0] new_sample,
    input  logic signed [SAMPLE_WIDTH-1:0] load_value,
    input  logic signed [SAMPLE_WIDTH-1:0] prev_sample,
    input  logic                           prev_mark,
    input  logic                           prev_valid,
    output logic signed [SAMPLE_WIDTH-1:0] sample,
    output logic                           mark,
    output logic                           valid,
    output logic                           neg_hit,
    output logic                           pos_hit
);

    localparam int EW = swm_pkg::OFS_EXT_W;
    localparam int IW = swm_pkg::TABLE_IDX_W;
    localparam int SW = SAMPLE_WIDTH;
    localparam logic signed [EW-1:0] POS_OFS = EW'(AGE);
    localparam logic signed [EW-1:0] NEG_OFS = -POS_OFS;
    localparam bit COMPARE_EN = (AGE < WINDOW_SPAN);

    logic signed [SW-1:0] sample_reg;
    logic signed [SW-1:0] thr_neg_reg;
    logic signed [SW-1:0] thr_pos_reg;
    logic                 mark_reg;
    logic                 mark_next;
    logic                 valid_reg;
    logic                 valid_next;

    logic [EW-1:0]        key_neg;
    logic [EW-1:0]        key_pos;
    logic                 neg_in_range;
    logic                 pos_in_range;
    logic signed [SW:0]   own_ext;
    logic signed [SW:0]   new_ext;
    logic signed [SW:0]   sum_neg;
    logic signed [SW:0]   sum_pos;

    assign key_neg = NEG_OFS - ctrl.first;
    assign key_pos = POS_OFS - ctrl.first;

    assign neg_in_range = ctrl.active && (NEG_OFS >= ctrl.first) && (NEG_OFS <= ctrl.hi);
    assign pos_in_range = ctrl.active && (POS_OFS >= ctrl.first) && (POS_OFS <= ctrl.hi);

    assign own_ext = $signed({sample_reg[SW-1], sample_reg});
    assign new_ext = $signed({new_sample[SW-1], new_sample});
    assign sum_neg = own_ext + $signed({thr_neg_reg[SW-1], thr_neg_reg});
    assign sum_pos = new_ext + $signed({thr_pos_reg[SW-1], thr_pos_reg});

    assign neg_hit = COMPARE_EN && valid_reg && neg_in_range && (sum_neg < new_ext);
    assign pos_hit = COMPARE_EN && valid_reg && pos_in_range && (sum_pos < own_ext);

    always_comb
    begin
        mark_next  = mark_reg;
        valid_next = valid_reg;
        if (ctrl.shift)
        begin
            mark_next  = prev_mark;
            valid_next = prev_valid && !ctrl.col_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            mark_reg  <= mark_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            sample_reg <= prev_sample;
        end
        if (ctrl.load_en && (ctrl.load_idx == key_neg[IW-1:0]))
        begin
            thr_neg_reg <= load_value;
        end
        if (ctrl.load_en && (ctrl.load_idx == key_pos[IW-1:0]))
        begin
            thr_pos_reg <= load_value;
        end
    end

    assign sample = sample_reg;
    assign mark   = mark_reg;
    assign valid  = valid_reg;

endmodule

// File: hdl/sidelobe_window_mask.sv
// Sidelobe window mask over one column of log-power samples.
// Input stream s_*: tuser is the item kind (data sample or threshold write),
// tlast closes a column, tdata carries sample, table index and table value.
// Output stream m_*: one request per row with its mark and row number; tlast
// ends the results of one input, tuser flags the column's final row.
// Config channel cfg_*: register index and data, always ready.
// An item releases n rows (0 to WINDOW_SPAN): taking it shifts the cell
// row, then each result passes in turn through the single emission
// sequencer into the output register. With a negative first offset a
// steady column releases one row per sample. A row comes out -first_offset
// samples (at most WINDOW_SPAN-1) after it entered, the rest of the column
// right after its final sample. Each write to first_offset starts a copy of
// the threshold memory into the cells; input waits until the copy is done.
// The output register frees the input side: the next item is taken while the
// last result still waits. A stalled receiver holds the sequencer with the
// output register full. Reset clears the window, counters and output valid
// and restores first -1, last 1, masking on; the threshold memory is not
// cleared and must be written before use.
module sidelobe_window_mask #(
    parameter int  WINDOW_SPAN  = swm_pkg::WINDOW_SPAN_DEF,
    parameter int  SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF,
    parameter int  MAX_ROWS     = swm_pkg::MAX_ROWS_DEF,
    localparam int IN_DATA_W    = ((2 * SAMPLE_WIDTH + swm_pkg::TABLE_IDX_W + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // sample_value, table_index, table_value
    input  logic [IN_DATA_W-1:0]              s_tdata,
    // kind
    input  logic                              s_tuser,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // row_masked, row_index
    output logic [swm_pkg::OUT_DATA_W-1:0]    m_tdata,
    // last_of_column
    output logic                              m_tuser,
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [swm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [swm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int SW      = SAMPLE_WIDTH;
    localparam int W       = WINDOW_SPAN;
    localparam int EW      = swm_pkg::OFS_EXT_W;
    localparam int OW      = swm_pkg::OFFSET_W;
    localparam int IW      = swm_pkg::TABLE_IDX_W;
    localparam int RIW     = swm_pkg::ROW_INDEX_W;
    localparam int DEPTH   = swm_pkg::TABLE_DEPTH;
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int PEND_W  = $clog2(W + 1);
    localparam int IDX_W   = $clog2(W);
    localparam int SWEEP_W = $clog2(DEPTH + 1);
    localparam int EXT_W   = (ROW_W > RIW) ? ROW_W : RIW;
    localparam int OUT_PAD = swm_pkg::OUT_DATA_W - RIW - 1;
    localparam logic signed [EW-1:0] SPAN_MAX = EW'(DEPTH - 1);
    localparam logic signed [EW-1:0] LAG_MAX  = EW'(W - 1);
    localparam logic [SWEEP_W-1:0]   SWEEP_DONE = SWEEP_W'(DEPTH);
    localparam logic [ROW_W-1:0]     ROW_LAST   = ROW_W'(MAX_ROWS - 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EMIT  = 3'b010,
        ST_SWEEP = 3'b100
    } state_t;

    state_t                state_reg, state_next;

    logic signed [OW-1:0]  first_reg, first_next;
    logic signed [OW-1:0]  last_reg, last_next;
    logic                  enable_reg, enable_next;
    logic                  sweep_req_reg, sweep_req_next;
    logic [SWEEP_W-1:0]    sweep_cnt_reg, sweep_cnt_next;
    logic                  rd_pend_reg, rd_pend_next;
    logic [IW-1:0]         rd_idx_reg;
    logic signed [SW-1:0]  rd_data_reg;
    logic signed [SW-1:0]  table_mem [DEPTH];
    logic signed [SW-1:0]  thr_zero_reg;

    logic [ROW_W-1:0]      row_cnt_reg, row_cnt_next;
    logic [ROW_W-1:0]      item_row_reg;
    logic [PEND_W-1:0]     pending_reg, pending_next;
    logic [PEND_W-1:0]     keep_reg;
    logic                  end_reg;

    logic                  out_valid_reg, out_valid_next;
    logic                  out_mask_reg;
    logic [RIW-1:0]        out_row_reg;
    logic                  out_run_reg;
    logic                  out_col_reg;

    logic                  cfg_wr;
    logic                  first_wr;
    logic                  s_accept;
    logic                  data_acc;
    logic                  tbl_wr;
    logic signed [SW-1:0]  in_sample;
    logic [IW-1:0]         in_idx;
    logic signed [SW-1:0]  in_value;

    logic signed [EW-1:0]  first_ext;
    logic signed [EW-1:0]  last_ext;
    logic signed [EW-1:0]  span;
    logic signed [EW-1:0]  hi;
    logic signed [EW-1:0]  lag_ext;
    logic signed [EW-1:0]  zero_key;
    logic                  active;
    logic                  zero_hit;
    logic                  col_end;
    logic [PEND_W-1:0]     lag;
    logic [PEND_W-1:0]     keep_new;
    logic [PEND_W-1:0]     pending_inc;
    logic [PEND_W-1:0]     pend_m1;
    logic [IDX_W-1:0]      pend_idx;
    logic                  run_last;
    logic                  out_free;
    logic                  emit_load;
    logic [ROW_W-1:0]      emit_row;
    logic [EXT_W-1:0]      emit_row_ext;

    swm_pkg::cell_ctrl_t   ctrl;
    logic signed [SW-1:0]  load_value;
    logic signed [SW-1:0]  cell_sample [W];
    logic signed [SW-1:0]  chain_sample [W];
    logic [W-1:0]          cell_mark;
    logic [W-1:0]          cell_valid;
    logic [W-1:0]          cell_neg;
    logic [W-1:0]          cell_pos;
    logic [W-1:0]          chain_mark;
    logic [W-1:0]          chain_valid;

    assign in_sample = $signed(s_tdata[SW-1:0]);
    assign in_idx    = s_tdata[SW+IW-1:SW];
    assign in_value  = $signed(s_tdata[2*SW+IW-1:SW+IW]);

    assign s_accept = s_tvalid && s_tready;
    assign data_acc = s_accept && (s_tuser == swm_pkg::KIND_DATA);
    assign tbl_wr   = s_accept && (s_tuser == swm_pkg::KIND_TABLE);

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign first_wr  = cfg_wr && (cfg_index == swm_pkg::CFG_FIRST_OFFSET);

    always_comb
    begin
        first_next  = first_reg;
        last_next   = last_reg;
        enable_next = enable_reg;
        if (cfg_wr)
        begin
            unique case (swm_pkg::cfg_reg_t'(cfg_index))
                swm_pkg::CFG_FIRST_OFFSET:   first_next  = $signed(cfg_data[OW-1:0]);
                swm_pkg::CFG_LAST_OFFSET:    last_next   = $signed(cfg_data[OW-1:0]);
                swm_pkg::CFG_MASKING_ENABLE: enable_next = cfg_data[0];
                default:                     first_next  = first_reg;
            endcase
        end
    end

    // window bounds, clipped to the table span
    assign first_ext = $signed({{(EW - OW){first_reg[OW-1]}}, first_reg});
    assign last_ext  = $signed({{(EW - OW){last_reg[OW-1]}}, last_reg});
    assign span      = last_ext - first_ext;
    assign hi        = (span > SPAN_MAX) ? (first_ext + SPAN_MAX) : last_ext;
    assign active    = enable_reg && (hi >= first_ext);

    always_comb
    begin
        lag_ext = '0;
        if (active && (first_ext < 0))
        begin
            lag_ext = -first_ext;
            if (lag_ext > LAG_MAX)
            begin
                lag_ext = LAG_MAX;
            end
        end
    end

    assign lag      = lag_ext[PEND_W-1:0];
    assign col_end  = s_tlast || (row_cnt_reg >= ROW_LAST);
    assign keep_new = col_end ? '0 : lag;

    assign zero_key = -first_ext;
    assign zero_hit = active && (first_ext <= 0) && (hi >= 0) && thr_zero_reg[SW-1];

    // threshold loads come from a table-write item or from the copy sweep
    assign load_value    = tbl_wr ? in_value : rd_data_reg;
    assign ctrl.shift    = data_acc;
    assign ctrl.col_end  = col_end;
    assign ctrl.active   = active;
    assign ctrl.first    = first_ext;
    assign ctrl.hi       = hi;
    assign ctrl.load_en  = tbl_wr || rd_pend_reg;
    assign ctrl.load_idx = tbl_wr ? in_idx : rd_idx_reg;

    genvar c;
    generate
        for (c = 0; c < W; c++)
        begin : g_cell
            if (c == 0)
            begin : g_head
                assign chain_sample[c] = in_sample;
                assign chain_mark[c]   = zero_hit || (|cell_pos);
                assign chain_valid[c]  = 1'b1;
            end
            else
            begin : g_link
                assign chain_sample[c] = cell_sample[c-1];
                assign chain_mark[c]   = cell_mark[c-1] || cell_neg[c-1];
                assign chain_valid[c]  = cell_valid[c-1];
            end

            swm_cell #(
                .AGE          (c + 1),
                .WINDOW_SPAN  (W),
                .SAMPLE_WIDTH (SW)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .new_sample  (in_sample),
                .load_value  (load_value),
                .prev_sample (chain_sample[c]),
                .prev_mark   (chain_mark[c]),
                .prev_valid  (chain_valid[c]),
                .sample      (cell_sample[c]),
                .mark        (cell_mark[c]),
                .valid       (cell_valid[c]),
                .neg_hit     (cell_neg[c]),
                .pos_hit     (cell_pos[c])
            );
        end
    endgenerate

    // emission of the oldest pending row
    assign pending_inc  = pending_reg + 1'b1;
    assign pend_m1      = pending_reg - 1'b1;
    assign pend_idx     = pend_m1[IDX_W-1:0];
    assign run_last     = (pend_m1 == keep_reg);
    assign out_free     = !out_valid_reg || m_tready;
    assign emit_row     = item_row_reg + ROW_W'(1) - ROW_W'(pending_reg);
    assign emit_row_ext = EXT_W'(emit_row);

    always_comb
    begin
        state_next     = state_reg;
        emit_load      = 1'b0;
        sweep_cnt_next = sweep_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sweep_req_reg)
                begin
                    state_next     = ST_SWEEP;
                    sweep_cnt_next = '0;
                end
                else if (data_acc && (pending_inc > keep_new))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    emit_load = 1'b1;
                    if (run_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SWEEP:
            begin
                if (sweep_cnt_reg == SWEEP_DONE)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_cnt_next = sweep_cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE) && !sweep_req_reg;

    always_comb
    begin
        sweep_req_next = sweep_req_reg;
        if (first_wr)
        begin
            sweep_req_next = 1'b1;
        end
        else if (state_reg == ST_IDLE)
        begin
            sweep_req_next = 1'b0;
        end
    end

    assign rd_pend_next = (state_reg == ST_SWEEP) && (sweep_cnt_reg != SWEEP_DONE);

    always_comb
    begin
        row_cnt_next = row_cnt_reg;
        pending_next = pending_reg;
        if (data_acc)
        begin
            row_cnt_next = col_end ? '0 : (row_cnt_reg + 1'b1);
            pending_next = pending_inc;
        end
        else if (emit_load)
        begin
            pending_next = pend_m1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            first_reg     <= -6'sd1;
            last_reg      <= 6'sd1;
            enable_reg    <= 1'b1;
            sweep_req_reg <= 1'b0;
            sweep_cnt_reg <= '0;
            rd_pend_reg   <= 1'b0;
            row_cnt_reg   <= '0;
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            enable_reg    <= enable_next;
            sweep_req_reg <= sweep_req_next;
            sweep_cnt_reg <= sweep_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            row_cnt_reg   <= row_cnt_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_wr)
        begin
            table_mem[in_idx] <= in_value;
        end
        rd_data_reg <= table_mem[sweep_cnt_reg[IW-1:0]];
        rd_idx_reg  <= sweep_cnt_reg[IW-1:0];
        if (ctrl.load_en && (ctrl.load_idx == zero_key[IW-1:0]))
        begin
            thr_zero_reg <= load_value;
        end
        if (data_acc)
        begin
            item_row_reg <= row_cnt_reg;
            keep_reg     <= keep_new;
            end_reg      <= col_end;
        end
        if (emit_load)
        begin
            out_mask_reg <= cell_mark[pend_idx];
            out_row_reg  <= emit_row_ext[RIW-1:0];
            out_run_reg  <= run_last;
            out_col_reg  <= end_reg && (pending_reg == PEND_W'(1));
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD{1'b0}}, out_row_reg, out_mask_reg};
    assign m_tlast  = out_run_reg;
    assign m_tuser  = out_col_reg;

endmodule

// File: hdl/swm_checker.sv
`include "sidelobe_window_mask_defines.svh"

module swm_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [swm_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                           m_tlast,
    input logic                           m_tuser
);

    `SWM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
    `SWM_ASSERT_IMPLIES(a_col_ends_run, m_tvalid && m_tuser, m_tlast)
    `SWM_ASSERT_IMPLIES(a_no_take_mid_run, m_tvalid && !m_tlast, !s_tready)
    `SWM_ASSERT_NEXT(a_table_silent, !m_tvalid && s_tvalid && s_tready && (s_tuser == swm_pkg::KIND_TABLE), !m_tvalid)

endmodule

bind sidelobe_window_mask swm_checker u_swm_checker (.*);
